FILE: sv/i2c_blm_pkg.sv
// Package for the two-wire bus master: opcodes, sequencer phases, queue entry type
// and sequence lengths. No dependencies; front, queue, back, top level and testbench import it.
package i2c_blm_pkg;

    // Command opcodes as carried on the tick channel
    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_WRITE = 3'd1,
        OP_READ  = 3'd2,
        OP_ACK   = 3'd3,
        OP_STOP  = 3'd4
    } blm_op_t;

    // Sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_WRITE = 3'd2,
        PH_READ  = 3'd3,
        PH_ACK   = 3'd4,
        PH_STOP  = 3'd5
    } blm_phase_t;

    localparam int TICK_W      = 5;
    localparam int BYTE_W      = 8;
    localparam int QUEUE_DEPTH = 4;

    // Last tick of each sequence
    localparam logic [TICK_W-1:0] LEN_START = 5'd2;
    localparam logic [TICK_W-1:0] LEN_BYTE  = 5'd16;
    localparam logic [TICK_W-1:0] LEN_ACK   = 5'd3;
    localparam logic [TICK_W-1:0] LEN_STOP  = 5'd3;

    // Classified tick as it sits in the queue
    typedef struct packed {
        logic              cmd_valid;
        logic              op_known;
        blm_phase_t        phase;
        logic [BYTE_W-1:0] tx_byte;
        logic              sda_in;
    } blm_entry_t;

    // Number of the finishing tick for a phase
    function automatic logic [TICK_W-1:0] seq_len(input blm_phase_t ph);
        logic [TICK_W-1:0] len;
        case (ph)
            PH_START: len = LEN_START;
            PH_WRITE: len = LEN_BYTE;
            PH_READ:  len = LEN_BYTE;
            PH_ACK:   len = LEN_ACK;
            PH_STOP:  len = LEN_STOP;
            default:  len = '0;
        endcase
        return len;
    endfunction

endpackage

FILE: sv/i2c_blm_in_if.sv
// Tick channel: valid/ready handshake with command and sampled data line.
// Depends on nothing.
interface i2c_blm_in_if;
    logic       valid;
    logic       ready;
    logic       cmd_valid;
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       sda_in;

    modport source (output valid, output cmd_valid, output op, output tx_byte,
                    output sda_in, input ready);
    modport sink   (input valid, input cmd_valid, input op, input tx_byte,
                    input sda_in, output ready);
endinterface

FILE: sv/i2c_blm_out_if.sv
// Result channel: valid/ready handshake with line drive and status per tick.
// Depends on nothing.
interface i2c_blm_out_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_enable;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_bit;
    logic       cmd_dropped;

    modport source (output valid, output scl_level, output sda_enable,
                    output sda_level, output busy_res, output done_res,
                    output rx_byte, output ack_bit, output cmd_dropped,
                    input ready);
    modport sink   (input valid, input scl_level, input sda_enable,
                    input sda_level, input busy_res, input done_res,
                    input rx_byte, input ack_bit, input cmd_dropped,
                    output ready);
endinterface

FILE: sv/i2c_blm_front.sv
// Front end: accepts ticks and decodes the opcode into a sequencer phase.
// Depends on i2c_blm_pkg and i2c_blm_in_if.
module i2c_blm_front
    import i2c_blm_pkg::*;
(
    i2c_blm_in_if.sink  tick,
    output logic        push_valid,
    input  logic        push_ready,
    output blm_entry_t  push_entry
);

    // Map opcode to phase; unknown opcodes are marked so the back end ignores them
    always_comb
    begin
        push_entry.cmd_valid = tick.cmd_valid;
        push_entry.tx_byte   = tick.tx_byte;
        push_entry.sda_in    = tick.sda_in;
        push_entry.op_known  = 1'b1;
        case (tick.op)
            OP_START: push_entry.phase = PH_START;
            OP_WRITE: push_entry.phase = PH_WRITE;
            OP_READ:  push_entry.phase = PH_READ;
            OP_ACK:   push_entry.phase = PH_ACK;
            OP_STOP:  push_entry.phase = PH_STOP;
            default:
            begin
                push_entry.phase    = PH_IDLE;
                push_entry.op_known = 1'b0;
            end
        endcase
    end

    // Pass the handshake through to the queue
    assign push_valid = tick.valid;
    assign tick.ready = push_ready;

endmodule

FILE: sv/i2c_blm_queue.sv
// Short FIFO of classified ticks between front and back end.
// Depends on i2c_blm_pkg.
module i2c_blm_queue
    import i2c_blm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  blm_entry_t push_entry,
    output logic       pop_valid,
    input  logic       pop_ready,
    output blm_entry_t pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    blm_entry_t        slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_ready && pop_valid;
    assign pop_entry  = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap and track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: sv/i2c_blm_back.sv
// Back end: bus sequencer that runs one tick per queue entry, plus result register.
// Depends on i2c_blm_pkg and i2c_blm_out_if.
module i2c_blm_back
    import i2c_blm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  blm_entry_t    pop_entry,
    i2c_blm_out_if.source result
);

    blm_phase_t         phase_reg, phase_next;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic [BYTE_W-1:0]  shift_reg, shift_next;
    logic               scl_reg, scl_next;
    logic               sda_out_reg, sda_out_next;
    logic               sda_oe_reg, sda_oe_next;
    logic [BYTE_W-1:0]  rx_reg, rx_next;
    logic               ack_reg, ack_next;
    logic               res_valid_reg;
    logic               done_reg, done_next;
    logic               dropped_reg, dropped_next;

    logic               step;
    blm_phase_t         step_ph;
    logic [TICK_W-1:0]  step_t;
    logic [BYTE_W-1:0]  sh;
    logic               sda;

    // Take the next tick when the result register is free or being drained
    assign pop_ready = !res_valid_reg || result.ready;
    assign sda       = pop_entry.sda_in;

    // Next state and line drive for one tick
    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        shift_next   = shift_reg;
        scl_next     = scl_reg;
        sda_out_next = sda_out_reg;
        sda_oe_next  = sda_oe_reg;
        rx_next      = rx_reg;
        ack_next     = ack_reg;
        done_next    = 1'b0;
        dropped_next = 1'b0;
        step         = 1'b0;
        step_ph      = phase_reg;
        step_t       = tick_reg + TICK_W'(1);
        sh           = shift_reg;

        if (phase_reg != PH_IDLE)
        begin
            dropped_next = pop_entry.cmd_valid;
            step         = 1'b1;
        end
        else if (pop_entry.cmd_valid && pop_entry.op_known)
        begin
            step    = 1'b1;
            step_ph = pop_entry.phase;
            step_t  = '0;
            if (pop_entry.phase == PH_WRITE)
            begin
                sh = pop_entry.tx_byte;
            end
        end

        // Line actions of the current sequence at tick step_t
        if (step)
        begin
            shift_next = sh;
            case (step_ph)
                PH_START:
                begin
                    if (step_t == 5'd0)
                    begin
                        sda_oe_next  = 1'b1;
                        sda_out_next = 1'b1;
                        scl_next     = 1'b1;
                    end
                    else if (step_t == 5'd1)
                    begin
                        sda_out_next = 1'b0;
                    end
                    else if (step_t == 5'd2)
                    begin
                        scl_next = 1'b0;
                    end
                end
                PH_WRITE:
                begin
                    if (step_t == 5'd0)
                    begin
                        sda_oe_next  = 1'b1;
                        sda_out_next = sh[BYTE_W-1];
                        shift_next   = {sh[BYTE_W-2:0], 1'b0};
                    end
                    else if (step_t[0])
                    begin
                        scl_next = 1'b1;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                        if (step_t < LEN_BYTE)
                        begin
                            sda_out_next = sh[BYTE_W-1];
                            shift_next   = {sh[BYTE_W-2:0], 1'b0};
                        end
                    end
                end
                PH_READ:
                begin
                    if (step_t == 5'd0)
                    begin
                        sda_oe_next = 1'b0;
                        shift_next  = '0;
                    end
                    else if (step_t[0])
                    begin
                        scl_next = 1'b1;
                    end
                    else
                    begin
                        shift_next = {sh[BYTE_W-2:0], sda};
                        scl_next   = 1'b0;
                        if (step_t == LEN_BYTE)
                        begin
                            rx_next = {sh[BYTE_W-2:0], sda};
                        end
                    end
                end
                PH_ACK:
                begin
                    if (step_t == 5'd0)
                    begin
                        sda_oe_next = 1'b0;
                    end
                    else if (step_t == 5'd1)
                    begin
                        scl_next = 1'b1;
                    end
                    else if (step_t == 5'd2)
                    begin
                        ack_next = sda;
                        if (sda)
                        begin
                            sda_oe_next = 1'b1;
                        end
                        scl_next = 1'b0;
                    end
                end
                PH_STOP:
                begin
                    if (step_t == 5'd0)
                    begin
                        sda_oe_next  = 1'b1;
                        sda_out_next = 1'b0;
                    end
                    else if (step_t == 5'd1)
                    begin
                        scl_next = 1'b1;
                    end
                    else if (step_t == 5'd2)
                    begin
                        sda_out_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            // Advance the tick counter and finish on the last tick
            phase_next = step_ph;
            tick_next  = step_t;
            if (phase_reg != PH_IDLE && step_t >= seq_len(phase_reg))
            begin
                done_next  = 1'b1;
                phase_next = PH_IDLE;
                tick_next  = '0;
            end
        end
    end

    // Sequencer state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            shift_reg     <= '0;
            scl_reg       <= 1'b1;
            sda_out_reg   <= 1'b1;
            sda_oe_reg    <= 1'b1;
            rx_reg        <= '0;
            ack_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            dropped_reg   <= 1'b0;
        end
        else
        begin
            if (pop_ready)
            begin
                res_valid_reg <= pop_valid;
            end
            if (pop_ready && pop_valid)
            begin
                phase_reg   <= phase_next;
                tick_reg    <= tick_next;
                shift_reg   <= shift_next;
                scl_reg     <= scl_next;
                sda_out_reg <= sda_out_next;
                sda_oe_reg  <= sda_oe_next;
                rx_reg      <= rx_next;
                ack_reg     <= ack_next;
                done_reg    <= done_next;
                dropped_reg <= dropped_next;
            end
        end
    end

    // Present the item from the registered state
    assign result.valid       = res_valid_reg;
    assign result.scl_level   = scl_reg;
    assign result.sda_enable  = sda_oe_reg;
    assign result.sda_level   = sda_out_reg;
    assign result.busy_res    = (phase_reg != PH_IDLE);
    assign result.done_res    = done_reg;
    assign result.rx_byte     = rx_reg;
    assign result.ack_bit     = ack_reg;
    assign result.cmd_dropped = dropped_reg;

endmodule

FILE: sv/i2c_bit_level_master_top.sv
// Two-wire bus master driven by half-bit ticks. Each tick item yields exactly one
// result item with the clock/data drive and status after that tick. The block
// sustains one tick per clock cycle while the result side is ready: the front end
// decodes the opcode into a short queue, and the back-end sequencer applies one tick
// per cycle to its state and result register. An accepted tick passes the queue
// and the result register; the queue (QUEUE_DEPTH entries) absorbs result stalls.
// Depends on i2c_blm_pkg, the channel interfaces, front, queue and back modules.
module i2c_bit_level_master_top
    import i2c_blm_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    i2c_blm_in_if.sink    tick,
    i2c_blm_out_if.source result
);

    logic       push_valid, push_ready;
    logic       pop_valid, pop_ready;
    blm_entry_t push_entry, pop_entry;

    // Decode ticks
    i2c_blm_front u_front (
        .tick       (tick),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // Buffer decoded ticks
    i2c_blm_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // Run the bus sequencer
    i2c_blm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .result    (result)
    );

endmodule

FILE: sv/i2c_blm_checker.sv
// Port-level checks for the two-wire bus master, bound to the top level.
// Depends on the top level's channel signals only.
module i2c_blm_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       tick_valid,
    input logic       tick_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic       scl_level,
    input logic       sda_enable,
    input logic       sda_level,
    input logic       busy_res,
    input logic       done_res,
    input logic [7:0] rx_byte,
    input logic       ack_bit,
    input logic       cmd_dropped
);

    logic [7:0] inflight_reg, inflight_next;
    logic       tick_acc, res_acc;

    assign tick_acc = tick_valid && tick_ready;
    assign res_acc  = res_valid && res_ready;

    // Track items accepted but not yet delivered
    always_comb
    begin
        inflight_next = inflight_reg + 8'(tick_acc) - 8'(res_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // No result without a tick behind it
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> inflight_reg != 8'd0)
        else $error("result item with no accepted tick");

    // Finishing tick reports not busy
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && done_res |-> !busy_res)
        else $error("done and busy on the same result");

    // A drop only happens while a sequence runs or on its last tick
    a_drop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && cmd_dropped |-> busy_res || done_res)
        else $error("command dropped while idle");

    // Stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(scl_level)
            && $stable(sda_enable) && $stable(sda_level) && $stable(busy_res)
            && $stable(done_res) && $stable(rx_byte) && $stable(ack_bit)
            && $stable(cmd_dropped))
        else $error("stalled result changed");

endmodule

bind i2c_bit_level_master_top i2c_blm_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_valid  (tick.valid),
    .tick_ready  (tick.ready),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .scl_level   (result.scl_level),
    .sda_enable  (result.sda_enable),
    .sda_level   (result.sda_level),
    .busy_res    (result.busy_res),
    .done_res    (result.done_res),
    .rx_byte     (result.rx_byte),
    .ack_bit     (result.ack_bit),
    .cmd_dropped (result.cmd_dropped)
);

FILE: verif/i2c_bit_level_master_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for i2c_bit_level_master_top: drives half-bit tick items and
// checks every result item against a tick-accurate model of the bus sequencer.
// Depends on i2c_blm_pkg, i2c_blm_in_if, i2c_blm_out_if and i2c_bit_level_master_top.
module i2c_bit_level_master_top_tb;
    import i2c_blm_pkg::*;

    localparam int N_ITEMS      = 1150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_START   = 1000;
    localparam int HOLD_LEN     = 200;
    localparam int DRAIN_CYCLES = 8;
    localparam int SDA_RANDOM   = -1;

    typedef struct {
        logic       cmd_valid;
        logic [2:0] op;
        logic [7:0] tx_byte;
        logic       sda_in;
    } bus_tick_t;

    typedef struct {
        logic       scl_level;
        logic       sda_enable;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_bit;
        logic       cmd_dropped;
    } line_drive_t;

    logic clk;
    logic rst_n;

    i2c_blm_in_if  tick();
    i2c_blm_out_if result();

    i2c_bit_level_master_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick),
        .result (result)
    );

    // Stimulus and prediction storage
    bus_tick_t   tick_q[$];
    line_drive_t line_drive_q[$];
    bus_tick_t   cur_tick;
    line_drive_t want_drive;
    int          total_items;
    int          n_sent;
    int          err_count;
    int          tx_gap;
    int          rx_stall;
    bit          tx_burst;
    bit          rx_burst;
    int          hold_cnt;
    logic        hold_active;
    int          cycle_cnt;

    // Sequencer model state
    blm_phase_t  m_phase;
    logic [4:0]  m_tick;
    logic [7:0]  m_shift;
    logic [7:0]  m_rx;
    logic        m_scl;
    logic        m_sda_out;
    logic        m_sda_oe;
    logic        m_ack;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Number of the finishing tick of each sequence
    function automatic logic [4:0] seq_ticks(input blm_phase_t ph);
        case (ph)
            PH_START:          return 5'd2;
            PH_WRITE, PH_READ: return 5'd16;
            PH_ACK, PH_STOP:   return 5'd3;
            default:           return 5'd0;
        endcase
    endfunction

    // Apply one tick of the active sequence to the line and shift registers
    task automatic apply_tick(input logic [4:0] t, input logic sda);
        case (m_phase)
            PH_START:
            begin
                if (t == 5'd0)
                begin
                    m_sda_oe  = 1'b1;
                    m_sda_out = 1'b1;
                    m_scl     = 1'b1;
                end
                else if (t == 5'd1)
                    m_sda_out = 1'b0;
                else if (t == 5'd2)
                    m_scl = 1'b0;
            end
            PH_WRITE:
            begin
                if (t == 5'd0)
                begin
                    m_sda_oe  = 1'b1;
                    m_sda_out = m_shift[7];
                    m_shift   = {m_shift[6:0], 1'b0};
                end
                else if (t[0])
                    m_scl = 1'b1;
                else
                begin
                    m_scl = 1'b0;
                    // present the next bit, except after the last one
                    if (t < 5'd16)
                    begin
                        m_sda_out = m_shift[7];
                        m_shift   = {m_shift[6:0], 1'b0};
                    end
                end
            end
            PH_READ:
            begin
                if (t == 5'd0)
                begin
                    m_sda_oe = 1'b0;
                    m_shift  = 8'h00;
                end
                else if (t[0])
                    m_scl = 1'b1;
                else
                begin
                    m_shift = {m_shift[6:0], sda};
                    m_scl   = 1'b0;
                    if (t == 5'd16)
                        m_rx = m_shift;
                end
            end
            PH_ACK:
            begin
                if (t == 5'd0)
                    m_sda_oe = 1'b0;
                else if (t == 5'd1)
                    m_scl = 1'b1;
                else if (t == 5'd2)
                begin
                    m_ack = sda;
                    // a missing acknowledge takes the data line back
                    if (sda)
                        m_sda_oe = 1'b1;
                    m_scl = 1'b0;
                end
            end
            PH_STOP:
            begin
                if (t == 5'd0)
                begin
                    m_sda_oe  = 1'b1;
                    m_sda_out = 1'b0;
                end
                else if (t == 5'd1)
                    m_scl = 1'b1;
                else if (t == 5'd2)
                    m_sda_out = 1'b1;
            end
            default: ;
        endcase
    endtask

    // Advance the sequencer model by one accepted tick and store its line drive
    task automatic step_bus_master(input bus_tick_t it);
        line_drive_t d;
        logic        dropped;
        logic        done;
        dropped = 1'b0;
        done    = 1'b0;
        if (m_phase != PH_IDLE)
        begin
            // commands while busy are dropped, even on the finishing tick
            if (it.cmd_valid)
                dropped = 1'b1;
            m_tick = m_tick + 5'd1;
            apply_tick(m_tick, it.sda_in);
            if (m_tick >= seq_ticks(m_phase))
            begin
                done    = 1'b1;
                m_phase = PH_IDLE;
                m_tick  = 5'd0;
            end
        end
        else if (it.cmd_valid && it.op <= OP_STOP)
        begin
            m_phase = blm_phase_t'(it.op + 3'd1);
            m_tick  = 5'd0;
            if (m_phase == PH_WRITE)
                m_shift = it.tx_byte;
            apply_tick(5'd0, it.sda_in);
        end
        d.scl_level   = m_scl;
        d.sda_enable  = m_sda_oe;
        d.sda_level   = m_sda_out;
        d.busy_res    = (m_phase != PH_IDLE);
        d.done_res    = done;
        d.rx_byte     = m_rx;
        d.ack_bit     = m_ack;
        d.cmd_dropped = dropped;
        line_drive_q.push_back(d);
    endtask

    // Idle length for either side: mostly short, a few long, with gap-free stretches
    function automatic int pick_idle(inout bit burst);
        int roll;
        if ($urandom_range(0, 99) < 3)
            burst = !burst;
        if (burst)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 25);
    endfunction

    function automatic logic pick_sda(input int sda_fix);
        if (sda_fix == SDA_RANDOM)
            return 1'($urandom_range(0, 1));
        return sda_fix[0];
    endfunction

    task automatic queue_tick(input logic cv, input logic [2:0] op, input logic [7:0] tx,
                              input logic sda);
        bus_tick_t it;
        it.cmd_valid = cv;
        it.op        = op;
        it.tx_byte   = tx;
        it.sda_in    = sda;
        tick_q.push_back(it);
    endtask

    // Queue a command and the busy ticks that follow it; noise_pct adds stray commands
    task automatic queue_cmd(input blm_op_t op, input logic [7:0] tx, input int sda_fix,
                             input int noise_pct);
        int n_busy;
        n_busy = int'(seq_ticks(blm_phase_t'(op + 3'd1)));
        queue_tick(1'b1, op, tx, pick_sda(sda_fix));
        for (int k = 0; k < n_busy; k++)
            queue_tick($urandom_range(0, 99) < noise_pct, 3'($urandom_range(0, 7)),
                       8'($urandom_range(0, 255)), pick_sda(sda_fix));
    endtask

    // Compare one result field
    function automatic void cmp_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_count++;
        end
    endfunction

    // Tick driver: offer the next pending item, hold it until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick.valid     <= 1'b0;
            tick.cmd_valid <= 1'b0;
            tick.op        <= OP_START;
            tick.tx_byte   <= 8'h00;
            tick.sda_in    <= 1'b1;
            tx_gap = 0;
        end
        else
        begin
            if (tick.valid && tick.ready)
            begin
                step_bus_master(cur_tick);
                n_sent++;
            end
            if (!tick.valid || tick.ready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    tick.valid <= 1'b0;
                end
                else if (tick_q.size() != 0)
                begin
                    cur_tick = tick_q.pop_front();
                    tick.cmd_valid <= cur_tick.cmd_valid;
                    tick.op        <= cur_tick.op;
                    tick.tx_byte   <= cur_tick.tx_byte;
                    tick.sda_in    <= cur_tick.sda_in;
                    tick.valid     <= 1'b1;
                    tx_gap = pick_idle(tx_burst);
                end
                else
                    tick.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off so the block fills up and stalls its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt    <= 0;
            hold_active <= 1'b0;
        end
        else
        begin
            hold_cnt    <= hold_cnt + 1;
            hold_active <= (hold_cnt >= HOLD_START) && (hold_cnt < HOLD_START + HOLD_LEN);
        end
    end

    // Result monitor: check each accepted item, then decide on ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            rx_stall = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (line_drive_q.size() == 0)
                begin
                    $error("result item arrived with no prediction pending");
                    err_count++;
                end
                else
                begin
                    want_drive = line_drive_q.pop_front();
                    cmp_field("scl_level",   8'(want_drive.scl_level),
                              8'(result.scl_level));
                    cmp_field("sda_enable",  8'(want_drive.sda_enable),
                              8'(result.sda_enable));
                    cmp_field("sda_level",   8'(want_drive.sda_level),
                              8'(result.sda_level));
                    cmp_field("busy_res",    8'(want_drive.busy_res),
                              8'(result.busy_res));
                    cmp_field("done_res",    8'(want_drive.done_res),
                              8'(result.done_res));
                    cmp_field("rx_byte",     want_drive.rx_byte,     result.rx_byte);
                    cmp_field("ack_bit",     8'(want_drive.ack_bit),
                              8'(result.ack_bit));
                    cmp_field("cmd_dropped", 8'(want_drive.cmd_dropped),
                              8'(result.cmd_dropped));
                end
            end
            if (hold_active)
                result.ready <= 1'b0;
            else if (rx_stall > 0)
            begin
                rx_stall--;
                result.ready <= 1'b0;
            end
            else
            begin
                result.ready <= 1'b1;
                rx_stall = pick_idle(rx_burst);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int noise;
        n_sent    = 0;
        err_count = 0;
        cycle_cnt = 0;
        tx_burst  = 1'b0;
        rx_burst  = 1'b0;

        m_phase   = PH_IDLE;
        m_tick    = 5'd0;
        m_shift   = 8'h00;
        m_rx      = 8'h00;
        m_scl     = 1'b1;
        m_sda_out = 1'b1;
        m_sda_oe  = 1'b1;
        m_ack     = 1'b0;

        // Directed: idle tick, unknown ops while idle
        queue_tick(1'b0, OP_START, 8'h00, 1'b1);
        for (int k = OP_STOP + 1; k < 8; k++)
            queue_tick(1'b1, k[2:0], 8'hFF, 1'b0);
        // start with a command on every busy tick, finishing tick included
        queue_cmd(OP_START, 8'h00, SDA_RANDOM, 100);
        queue_cmd(OP_WRITE, 8'hFF, SDA_RANDOM, 0);
        queue_cmd(OP_ACK,   8'h00, 1, 0);
        queue_cmd(OP_READ,  8'h00, 1, 0);
        queue_cmd(OP_ACK,   8'h00, 0, 0);
        queue_cmd(OP_WRITE, 8'h00, SDA_RANDOM, 0);
        queue_cmd(OP_STOP,  8'h00, SDA_RANDOM, 0);

        // Random: mostly framed transfers, some broken ones and raw noise
        while (tick_q.size() < N_ITEMS)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                noise = ($urandom_range(0, 3) == 0) ? 15 : 0;
                if ($urandom_range(0, 9) != 0)
                    queue_cmd(OP_START, 8'($urandom_range(0, 255)), SDA_RANDOM, noise);
                queue_cmd(OP_WRITE, 8'($urandom_range(0, 255)), SDA_RANDOM, noise);
                queue_cmd(OP_ACK, 8'($urandom_range(0, 255)), SDA_RANDOM, noise);
                repeat ($urandom_range(0, 3))
                begin
                    if ($urandom_range(0, 1))
                        queue_cmd(OP_WRITE, 8'($urandom_range(0, 255)), SDA_RANDOM, noise);
                    else
                        queue_cmd(OP_READ, 8'($urandom_range(0, 255)), SDA_RANDOM, noise);
                    queue_cmd(OP_ACK, 8'($urandom_range(0, 255)), SDA_RANDOM, noise);
                end
                if ($urandom_range(0, 9) != 0)
                    queue_cmd(OP_STOP, 8'($urandom_range(0, 255)), SDA_RANDOM, noise);
                repeat ($urandom_range(0, 2))
                    queue_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)));
            end
            else
            begin
                repeat ($urandom_range(1, 12))
                    queue_tick(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                               8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end
        total_items = tick_q.size();

        // let the clocked blocks reach their event controls before reset falls
        #0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (n_sent < total_items || line_drive_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: i2c_bit_level_master_top.f
sv/i2c_blm_pkg.sv
sv/i2c_blm_in_if.sv
sv/i2c_blm_out_if.sv
sv/i2c_blm_front.sv
sv/i2c_blm_queue.sv
sv/i2c_blm_back.sv
sv/i2c_bit_level_master_top.sv
sv/i2c_blm_checker.sv
verif/i2c_bit_level_master_top_tb.sv
